// ----- hdl/bpse_pkg.sv -----
// Shared types and constants for the byte pair substitution encoder.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package bpse_pkg;

   // Pair table geometry
   localparam int PAIR_ENTRIES = 64;
   localparam int IDX_W        = $clog2(PAIR_ENTRIES);
   localparam int COUNT_W      = 7;

   // Pair codes start here
   localparam logic [7:0] CODE_BASE = 8'd155;

   // Result queue: room for two results from one request plus slack
   localparam int RSP_QUEUE_DEPTH = 4;
   localparam int QPTR_W          = $clog2(RSP_QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(RSP_QUEUE_DEPTH + 1);

   typedef enum logic {
      CMD_DATA = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] data_byte;
      logic       word_end;
      logic [5:0] entry_index;
      logic [7:0] pair_first;
      logic [7:0] pair_second;
   } req_type;

   typedef struct packed {
      logic [7:0] code_byte;
      logic       code_last;
   } rsp_type;

   // Pair table write port
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] index;
      logic [15:0]      pair;
   } tbl_wr_type;

   // Lowest matching table entry
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] index;
   } match_type;

endpackage

`default_nettype wire

// ----- hdl/bpse_match.sv -----
// Pair table storage with a parallel compare and lowest-index pick.
// Depends on bpse_pkg.
`default_nettype none

module bpse_match (
   input  wire                         clock,
   input  bpse_pkg::tbl_wr_type        tbl_wr,
   input  wire [bpse_pkg::COUNT_W-1:0] pair_count,
   input  wire [7:0]                   first_byte,
   input  wire [7:0]                   second_byte,
   output bpse_pkg::match_type         match
);
   import bpse_pkg::*;

   logic [15:0]             table_ff [PAIR_ENTRIES];
   logic [PAIR_ENTRIES-1:0] hit_vec;

   // Table write; no reset, entries are defined once loaded
   always_ff @(posedge clock) begin
      if (tbl_wr.en) begin
         table_ff[tbl_wr.index] <= tbl_wr.pair;
      end
   end

   // One comparator per entry, only entries below the count take part
   always_comb begin
      for (int i = 0; i < PAIR_ENTRIES; i++) begin
         hit_vec[i] = (32'(pair_count) > i) &&
                      (table_ff[i] == {first_byte, second_byte});
      end
   end

   // Lowest index wins
   always_comb begin
      match.hit   = |hit_vec;
      match.index = '0;
      for (int i = PAIR_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec[i]) begin
            match.index = IDX_W'(i);
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/bpse_rsp_queue.sv -----
// Small result queue: takes up to two results a cycle, hands out one when not stalled.
// Depends on bpse_pkg.
`default_nettype none

module bpse_rsp_queue (
   input  wire                clock,
   input  wire                reset,
   input  wire [1:0]          push_count,
   input  bpse_pkg::rsp_type  push_data0,
   input  bpse_pkg::rsp_type  push_data1,
   output logic               space_ok,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output bpse_pkg::rsp_type  rsp_data
);
   import bpse_pkg::*;

   rsp_type           mem_ff [RSP_QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              pop;
   logic [QPTR_W-1:0] wr_ptr_next;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && !rsp_stall;
   assign space_ok    = (32'(count_ff) <= RSP_QUEUE_DEPTH - 2);
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);

   // Pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_count);
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push_count) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, written at the tail
   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_data0;
      end
      if (push_count == 2'd2) begin
         mem_ff[wr_ptr_next] <= push_data1;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/byte_pair_substitution_encoder.sv -----
// Byte pair substitution encoder, top level.
// A request is registered in the request stage, and its results are
//   written into the result queue, from which they are offered.
// Throughput: one request per cycle while the result queue has room for two
//   results; the result queue hands out the results one at a time.
// Reset clears the pending byte, the pair count, the request stage and the
//   result queue; the pair table keeps its contents and must be loaded.
// Depends on bpse_pkg, bpse_match and bpse_rsp_queue.
`default_nettype none

module byte_pair_substitution_encoder (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_wr_en,
   input  wire [bpse_pkg::COUNT_W-1:0] csr_wr_data,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  bpse_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output bpse_pkg::rsp_type           rsp_data
);
   import bpse_pkg::*;

   logic [COUNT_W-1:0] pair_count_ff, pair_count_in;
   req_type            req_ff;
   logic               req_vld_ff, req_vld_in;
   logic [7:0]         held_byte_ff, held_byte_in;
   logic               held_valid_ff, held_valid_in;

   logic       space_ok;
   logic       advance;
   logic       data_go;
   tbl_wr_type tbl_wr;
   match_type  match;
   logic [1:0] push_count;
   rsp_type    push_data0;
   rsp_type    push_data1;

   // Configuration register
   assign pair_count_in = csr_wr_en ? csr_wr_data : pair_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_count_ff <= '0;
      end else begin
         pair_count_ff <= pair_count_in;
      end
   end

   // Request stage; moves on when the queue has room for two results
   assign advance    = req_vld_ff && space_ok;
   assign req_stall  = req_vld_ff && !space_ok;
   assign req_vld_in = req_stall ? req_vld_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_vld_ff <= 1'b0;
      end else begin
         req_vld_ff <= req_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         req_ff <= req_data;
      end
   end

   // Table loads
   always_comb begin
      tbl_wr.en    = advance && (req_ff.command == CMD_LOAD) &&
                     (32'(req_ff.entry_index) < PAIR_ENTRIES);
      tbl_wr.index = IDX_W'(req_ff.entry_index);
      tbl_wr.pair  = {req_ff.pair_first, req_ff.pair_second};
   end

   bpse_match u_match (
      .clock       (clock),
      .tbl_wr      (tbl_wr),
      .pair_count  (pair_count_ff),
      .first_byte  (held_byte_ff),
      .second_byte (req_ff.data_byte),
      .match       (match)
   );

   // Encode: pair code, literal, or flush at word end
   assign data_go = advance && (req_ff.command == CMD_DATA);

   always_comb begin
      push_count    = 2'd0;
      push_data0    = '{code_byte: req_ff.data_byte, code_last: 1'b1};
      push_data1    = '{code_byte: req_ff.data_byte, code_last: 1'b1};
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      if (data_go) begin
         if (!held_valid_ff) begin
            if (req_ff.word_end) begin
               push_count    = 2'd1;
               held_byte_in  = '0;
               held_valid_in = 1'b0;
            end else begin
               held_byte_in  = req_ff.data_byte;
               held_valid_in = 1'b1;
            end
         end else if (match.hit) begin
            push_count           = 2'd1;
            push_data0.code_byte = CODE_BASE + 8'(match.index);
            push_data0.code_last = req_ff.word_end;
            held_byte_in         = '0;
            held_valid_in        = 1'b0;
         end else begin
            push_data0 = '{code_byte: held_byte_ff, code_last: 1'b0};
            if (req_ff.word_end) begin
               push_count    = 2'd2;
               held_byte_in  = '0;
               held_valid_in = 1'b0;
            end else begin
               push_count    = 2'd1;
               held_byte_in  = req_ff.data_byte;
               held_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
      end
   end

   bpse_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_count (push_count),
      .push_data0 (push_data0),
      .push_data1 (push_data1),
      .space_ok   (space_ok),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire

// ----- hdl/bpse_checker.sv -----
// Port-level checks for the byte pair substitution encoder, bound to the top.
// Depends on bpse_pkg and byte_pair_substitution_encoder.
`default_nettype none

module bpse_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         req_valid,
   input wire                         req_stall,
   input wire                         rsp_valid,
   input wire                         rsp_stall,
   input bpse_pkg::rsp_type           rsp_data
);
   import bpse_pkg::*;

   // A stalled result stays offered
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result does not change
   a_rsp_stable : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data))
      else $error("stalled result changed");

   // Reset leaves no result and no back-pressure
   a_reset_clear : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("state not cleared by reset");

   // A result appearing on an empty output comes from an accepted request
   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

endmodule

bind byte_pair_substitution_encoder bpse_checker u_bpse_checker (.*);

`default_nettype wire

// ----- tb/byte_pair_substitution_encoder_test.sv -----
// Self-checking testbench for the byte pair substitution encoder.
// Holds a scoreboard class that predicts pair codes, plus driver tasks.
// Depends on bpse_pkg and the byte_pair_substitution_encoder top level.
`default_nettype none

module byte_pair_substitution_encoder_test;

   import bpse_pkg::*;

   // Predicts the code stream from accepted requests and checks the results
   class substitution_scoreboard;
      logic [15:0] pairs [PAIR_ENTRIES];
      logic [7:0]  held_byte;
      bit          held_valid;
      int          pair_count;
      rsp_type     expected_codes [$];
      int          errors;
      int          codes_checked;
      int          requests_seen;
      int          loads_seen;
      int          substitutions;

      function new();
         held_byte     = '0;
         held_valid    = 1'b0;
         pair_count    = 0;
         errors        = 0;
         codes_checked = 0;
         requests_seen = 0;
         loads_seen    = 0;
         substitutions = 0;
      endfunction

      function void set_count(int value);
         pair_count = value;
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction

      function void push_code(logic [7:0] code, logic last);
         rsp_type c;
         c.code_byte = code;
         c.code_last = last;
         expected_codes.push_back(c);
      endfunction

      // Encode one accepted request into zero, one or two expected codes
      function void take_request(req_type r);
         int limit;
         int hit;
         requests_seen++;
         if (r.command == CMD_LOAD) begin
            loads_seen++;
            pairs[r.entry_index] = {r.pair_first, r.pair_second};
         end else if (!held_valid) begin
            if (r.word_end) begin
               push_code(r.data_byte, 1'b1);
            end else begin
               held_byte  = r.data_byte;
               held_valid = 1'b1;
            end
         end else begin
            // lowest matching entry below the count wins
            limit = (pair_count > PAIR_ENTRIES) ? PAIR_ENTRIES : pair_count;
            hit   = -1;
            for (int i = 0; i < limit; i++) begin
               if (hit < 0 && pairs[i] == {held_byte, r.data_byte})
                  hit = i;
            end
            if (hit >= 0) begin
               substitutions++;
               push_code(CODE_BASE + hit[7:0], r.word_end);
               held_valid = 1'b0;
               held_byte  = '0;
            end else begin
               push_code(held_byte, 1'b0);
               if (r.word_end) begin
                  push_code(r.data_byte, 1'b1);
                  held_valid = 1'b0;
                  held_byte  = '0;
               end else begin
                  held_byte = r.data_byte;
               end
            end
         end
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $realtime, what);
         errors++;
      endtask

      // Compare one accepted result with the oldest expected code
      task check_code(rsp_type got);
         rsp_type want;
         if (expected_codes.size() == 0) begin
            report_mismatch($sformatf("unexpected code %h last %b",
                                      got.code_byte, got.code_last));
            return;
         end
         want = expected_codes.pop_front();
         codes_checked++;
         if (got.code_byte !== want.code_byte)
            report_mismatch($sformatf("code_byte %h, expected %h (code %0d)",
                                      got.code_byte, want.code_byte, codes_checked));
         if (got.code_last !== want.code_last)
            report_mismatch($sformatf("code_last %b, expected %b (code %0d)",
                                      got.code_last, want.code_last, codes_checked));
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_wr_en;
   logic [COUNT_W-1:0]  csr_wr_data;
   logic                req_valid;
   logic                req_stall;
   req_type             req_data;
   logic                rsp_valid;
   logic                rsp_stall;
   rsp_type             rsp_data;

   substitution_scoreboard sb;
   bit sender_idle;
   bit recv_idle;
   bit hold_off_request;

   byte_pair_substitution_encoder DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

   always #4 clock = ~clock;

   // Mostly a small alphabet so that pairs match often
   function automatic logic [7:0] pick_char();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 80)
         return 8'h41 + 8'($urandom_range(0, 7));
      else if (roll < 95)
         return 8'($urandom_range(1, 255));
      else if (roll < 97)
         return 8'h00;
      else if (roll < 99)
         return 8'hFF;
      return 8'h01;
   endfunction

   // Data request; the load fields are don't-care
   function automatic req_type make_data(logic [7:0] ch, logic last);
      req_type r;
      r.command     = CMD_DATA;
      r.data_byte   = ch;
      r.word_end    = last;
      r.entry_index = 6'($urandom_range(0, 63));
      r.pair_first  = 8'($urandom_range(0, 255));
      r.pair_second = 8'($urandom_range(0, 255));
      return r;
   endfunction

   // Load request; data_byte and word_end are don't-care
   function automatic req_type make_load(int idx, logic [7:0] first, logic [7:0] second);
      req_type r;
      r.command     = CMD_LOAD;
      r.data_byte   = 8'($urandom_range(0, 255));
      r.word_end    = 1'($urandom_range(0, 1));
      r.entry_index = idx[5:0];
      r.pair_first  = first;
      r.pair_second = second;
      return r;
   endfunction

   // Offer one request and wait for it to be taken
   task automatic send_request(req_type r);
      int gap;
      gap = sender_idle ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.take_request(r);
   endtask

   // Stop offering and let every expected code and any load in flight clear
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_pair_count(int value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[COUNT_W-1:0];
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.set_count(value);
   endtask

   // Random words with loads and stray end marks mixed in
   task automatic run_phase(int n_items, bit s_idle, bit r_idle);
      int word_left;
      int roll;
      req_type r;
      sender_idle = s_idle;
      recv_idle   = r_idle;
      word_left   = $urandom_range(1, 6);
      repeat (n_items) begin
         roll = $urandom_range(0, 99);
         if (roll < 10) begin
            r = make_load($urandom_range(0, 63), pick_char(), pick_char());
         end else if (roll < 15) begin
            r = make_data(pick_char(), 1'($urandom_range(0, 1)));
         end else begin
            word_left--;
            r = make_data(pick_char(), word_left == 0);
            if (word_left == 0) word_left = $urandom_range(1, 6);
         end
         send_request(r);
      end
   endtask

   // Result side: random stalls, one long hold-off on request
   initial begin
      int stall_cycles;
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            stall_cycles     = 60;
         end else begin
            stall_cycles = recv_idle ? $urandom_range(0, 9) : 0;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         sb.check_code(rsp_data);
      end
   end

   // Watchdog
   initial begin
      #2000000;
      $display("FAIL byte_pair_substitution_encoder");
      $finish;
   end

   // Main sequence
   initial begin
      int counts [10];
      int i;
      sb               = new();
      sender_idle      = 1'b1;
      recv_idle        = 1'b1;
      hold_off_request = 1'b0;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_valid   <= 1'b0;
      req_data    <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: no pairs searched, single byte word and field extremes
      write_pair_count(0);
      send_request(make_data(8'h01, 1'b1));
      send_request(make_data(8'hFF, 1'b0));
      send_request(make_data(8'h80, 1'b1));

      // Load a few entries; entry 1 duplicates entry 0 so the lower must win
      send_request(make_load(0, 8'h41, 8'h42));
      send_request(make_load(1, 8'h41, 8'h42));
      send_request(make_load(2, 8'h43, 8'h44));
      send_request(make_load(63, 8'hFF, 8'hFF));
      send_request(make_load(3, 8'hFF, 8'h01));
      wait_idle();
      write_pair_count(4);

      // Match on the final byte, then a match followed by a flushed literal
      send_request(make_data(8'h41, 1'b0));
      send_request(make_data(8'h42, 1'b1));
      send_request(make_data(8'h41, 1'b0));
      send_request(make_data(8'h42, 1'b0));
      send_request(make_data(8'h43, 1'b1));
      // a load mid-pair leaves the pending byte alone
      send_request(make_data(8'h43, 1'b0));
      send_request(make_load(3, 8'hFF, 8'h01));
      send_request(make_data(8'h44, 1'b0));
      send_request(make_data(8'h58, 1'b1));
      send_request(make_data(8'hFF, 1'b0));
      send_request(make_data(8'h01, 1'b1));
      // zero byte as an ordinary character, and a pair with no match
      send_request(make_data(8'h00, 1'b1));
      send_request(make_data(8'h41, 1'b0));
      send_request(make_data(8'h43, 1'b1));
      wait_idle();

      // Only entry 0 searched
      write_pair_count(1);
      send_request(make_data(8'h43, 1'b0));
      send_request(make_data(8'h44, 1'b1));
      send_request(make_data(8'h41, 1'b0));
      send_request(make_data(8'h42, 1'b1));
      wait_idle();

      // Fill the whole table, with words interleaved, four entries searched
      write_pair_count(4);
      sender_idle = 1'b1;
      recv_idle   = 1'b1;
      for (i = 0; i < PAIR_ENTRIES; i++) begin
         send_request(make_load(i, pick_char(), pick_char()));
         if ($urandom_range(0, 1) == 1)
            send_request(make_data(pick_char(), 1'($urandom_range(0, 1))));
      end
      wait_idle();

      // Random phases over a spread of pair counts
      counts = '{64, 127, 0, 1, 65, 63, 2, 32, 0, 0};
      counts[8] = $urandom_range(0, 127);
      counts[9] = $urandom_range(0, 127);
      for (i = 0; i < 10; i++) begin
         write_pair_count(counts[i]);
         if (i == 3) begin
            // receiver holds off while requests keep coming
            hold_off_request = 1'b1;
            run_phase(105, 1'b0, 1'b1);
         end else if (i == 2) begin
            run_phase(105, 1'b0, 1'b0);
         end else begin
            run_phase(105, (i % 3) != 1, (i % 4) != 1);
         end
         wait_idle();
      end

      // Drain and settle
      req_valid <= 1'b0;
      for (i = 0; i < 4000 && sb.pending() != 0; i++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.pending() != 0)
         sb.report_mismatch($sformatf("%0d codes never arrived", sb.pending()));

      $display("Covered %0d requests (%0d table loads), %0d codes checked,",
               sb.requests_seen, sb.loads_seen, sb.codes_checked);
      $display("including %0d pair substitutions over pair counts from 0 to 127.",
               sb.substitutions);
      if (sb.errors == 0) begin
         $display("PASS byte_pair_substitution_encoder");
      end else begin
         $display("FAIL byte_pair_substitution_encoder");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- byte_pair_substitution_encoder.f -----
hdl/bpse_pkg.sv
hdl/bpse_match.sv
hdl/bpse_rsp_queue.sv
hdl/byte_pair_substitution_encoder.sv
hdl/bpse_checker.sv
tb/byte_pair_substitution_encoder_test.sv
